// ===== rtl/core/rsi_pkg.sv =====
// Shared constants and types for the ray/sphere intersection pipeline.
`timescale 1ns / 1ps

package rsi_pkg;

  // Default coordinate format: signed Q16.16 in 32 bits
  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;

  // Configuration register index width and register map
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X = 2'd0,
    REG_CENTER_Y = 2'd1,
    REG_CENTER_Z = 2'd2,
    REG_RADIUS   = 2'd3
  } cfg_reg_t;

endpackage

// ===== rtl/core/rsi_ray_if.sv =====
// Ray input channel: valid/ready with origin and direction payload.
`timescale 1ns / 1ps

interface rsi_ray_if #(
  parameter int CW = rsi_pkg::COORD_WIDTH_DEF
) ();
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] origin_x;
  logic signed [CW-1:0] origin_y;
  logic signed [CW-1:0] origin_z;
  logic signed [CW-1:0] dir_x;
  logic signed [CW-1:0] dir_y;
  logic signed [CW-1:0] dir_z;

  modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  input ready);
  modport sink   (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  output ready);
endinterface

// ===== rtl/core/rsi_res_if.sv =====
// Result channel: valid/ready with hit flag and distance.
`timescale 1ns / 1ps

interface rsi_res_if #(
  parameter int CW = rsi_pkg::COORD_WIDTH_DEF
) ();
  logic                 valid;
  logic                 ready;
  logic                 hit;
  logic signed [CW-1:0] distance;

  modport source (output valid, hit, distance, input ready);
  modport sink   (input valid, hit, distance, output ready);
endinterface

// ===== rtl/core/rsi_cfg_if.sv =====
// Configuration write channel: valid/ready with register index and data.
`timescale 1ns / 1ps

interface rsi_cfg_if #(
  parameter int CW = rsi_pkg::COORD_WIDTH_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic [rsi_pkg::CFG_IDX_W-1:0] index;
  logic [CW-1:0]                 data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/rsi_sqrt_cell.sv =====
// One cell of the square root chain: resolves one root bit per cycle while en is high.
`timescale 1ns / 1ps

module rsi_sqrt_cell #(
  parameter int SW    = 69,
  parameter int SIDEW = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              v_i,
  input  logic [2*SW-1:0]   rad_i,
  input  logic [SW+1:0]     rem_i,
  input  logic [SW-1:0]     root_i,
  input  logic [SIDEW-1:0]  side_i,
  output logic              v_o,
  output logic [2*SW-1:0]   rad_o,
  output logic [SW+1:0]     rem_o,
  output logic [SW-1:0]     root_o,
  output logic [SIDEW-1:0]  side_o
);

  logic [SW+3:0]    trial_rem;
  logic [SW+3:0]    trial_sub;
  logic             ge;
  logic             v_r;
  logic [2*SW-1:0]  rad_r;
  logic [SW+1:0]    rem_r;
  logic [SW-1:0]    root_r;
  logic [SIDEW-1:0] side_r;

  // Bring down two radicand bits and try root*4+1
  always_comb begin
    trial_rem = {rem_i, rad_i[2*SW-1 -: 2]};
    trial_sub = {2'b00, root_i, 2'b01};
    ge        = (trial_rem >= trial_sub);
  end

  // Valid bit of the cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_i;
    end
  end

  // Advance the partial root and remainder
  always_ff @(posedge clk) begin
    if (en) begin
      rad_r  <= rad_i << 2;
      rem_r  <= ge ? (SW + 2)'(trial_rem - trial_sub) : (SW + 2)'(trial_rem);
      root_r <= {root_i[SW-2:0], ge};
      side_r <= side_i;
    end
  end

  assign v_o    = v_r;
  assign rad_o  = rad_r;
  assign rem_o  = rem_r;
  assign root_o = root_r;
  assign side_o = side_r;

endmodule

// ===== rtl/core/rsi_div_cell.sv =====
// One cell of the divider chain: one quotient bit per cycle for both roots while en is high.
`timescale 1ns / 1ps

module rsi_div_cell #(
  parameter int NW    = 86,
  parameter int DVW   = 70,
  parameter int SIDEW = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             v_i,
  input  logic [NW-1:0]    num0_i,
  input  logic [DVW-1:0]   den0_i,
  input  logic [DVW-1:0]   rem0_i,
  input  logic [NW-1:0]    quo0_i,
  input  logic [NW-1:0]    num1_i,
  input  logic [DVW-1:0]   den1_i,
  input  logic [DVW-1:0]   rem1_i,
  input  logic [NW-1:0]    quo1_i,
  input  logic [SIDEW-1:0] side_i,
  output logic             v_o,
  output logic [NW-1:0]    num0_o,
  output logic [DVW-1:0]   den0_o,
  output logic [DVW-1:0]   rem0_o,
  output logic [NW-1:0]    quo0_o,
  output logic [NW-1:0]    num1_o,
  output logic [DVW-1:0]   den1_o,
  output logic [DVW-1:0]   rem1_o,
  output logic [NW-1:0]    quo1_o,
  output logic [SIDEW-1:0] side_o
);

  logic [DVW:0]     part0;
  logic [DVW:0]     part1;
  logic             ge0;
  logic             ge1;
  logic             v_r;
  logic [NW-1:0]    num0_r;
  logic [DVW-1:0]   den0_r;
  logic [DVW-1:0]   rem0_r;
  logic [NW-1:0]    quo0_r;
  logic [NW-1:0]    num1_r;
  logic [DVW-1:0]   den1_r;
  logic [DVW-1:0]   rem1_r;
  logic [NW-1:0]    quo1_r;
  logic [SIDEW-1:0] side_r;

  // Shift in the next dividend bit and compare against the divisor
  always_comb begin
    part0 = {rem0_i, num0_i[NW-1]};
    part1 = {rem1_i, num1_i[NW-1]};
    ge0   = (part0 >= {1'b0, den0_i});
    ge1   = (part1 >= {1'b0, den1_i});
  end

  // Valid bit of the cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_i;
    end
  end

  // Restoring step for both lanes
  always_ff @(posedge clk) begin
    if (en) begin
      num0_r <= num0_i << 1;
      den0_r <= den0_i;
      rem0_r <= ge0 ? DVW'(part0 - {1'b0, den0_i}) : DVW'(part0);
      quo0_r <= {quo0_i[NW-2:0], ge0};
      num1_r <= num1_i << 1;
      den1_r <= den1_i;
      rem1_r <= ge1 ? DVW'(part1 - {1'b0, den1_i}) : DVW'(part1);
      quo1_r <= {quo1_i[NW-2:0], ge1};
      side_r <= side_i;
    end
  end

  assign v_o    = v_r;
  assign num0_o = num0_r;
  assign den0_o = den0_r;
  assign rem0_o = rem0_r;
  assign quo0_o = quo0_r;
  assign num1_o = num1_r;
  assign den1_o = den1_r;
  assign rem1_o = rem1_r;
  assign quo1_o = quo1_r;
  assign side_o = side_r;

endmodule

// ===== rtl/core/ray_sphere_intersect.sv =====
// Top level: streaming ray/sphere intersection with a stable quadratic.
//
// Channels: in_ray takes one ray (origin, direction, signed fixed point with
// FRAC_BITS fraction bits) per transfer; out_res gives one result per ray,
// hit and the nearest non-negative ray parameter, saturated, or -1.0 on a
// miss. cfg_wr writes center_x/y/z (index 0..2) and radius (index 3); it is
// always ready and is meant to be used while no rays are in flight.
// Throughput: one ray per cycle while out_res is not stalled. Here
// SW = 2*COORD_WIDTH+5 is the length of the square root cell chain and
// NW = SW+1+FRAC_BITS the length of the divider cell chain (FRAC_BITS is 16
// at the default Q16.16). Six front stages form a, b, c and the discriminant.
// The whole pipeline advances together: when out_res is stalled with a
// result held, every stage holds and in_ray.ready drops; it rises again in
// the cycle the result transfers.
// Reset clears all valid bits and loads center 0, radius 1.0.
`timescale 1ns / 1ps

module ray_sphere_intersect #(
  parameter int COORD_WIDTH = rsi_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = rsi_pkg::FRAC_BITS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  rsi_ray_if.sink   in_ray,
  rsi_res_if.source out_res,
  rsi_cfg_if.sink   cfg_wr
);

  localparam int CW    = COORD_WIDTH;
  localparam int FB    = FRAC_BITS;
  localparam int LW    = CW + 1;
  localparam int AW    = 2 * CW;
  localparam int PW    = 2 * CW + 3;
  localparam int BW    = PW + 1;
  localparam int CCW   = 2 * CW + 3;
  localparam int DXW   = 2 * BW + 2;
  localparam int SW    = DXW / 2;
  localparam int QW    = SW + 2;
  localparam int DVW   = SW + 1;
  localparam int NW    = DVW + FB;
  localparam int SQSW  = AW + CCW + BW + 1;
  localparam int DSW   = 4;
  localparam int BLW   = BW / 2;
  localparam int BHW   = BW - BLW;
  localparam int ALW   = AW / 2;
  localparam int AHW   = AW - ALW;
  localparam int CLW   = BLW;
  localparam int CHW   = CCW - CLW;

  // Configuration registers
  logic signed [CW-1:0] cx_r, cy_r, cz_r;
  logic [CW-2:0]        rad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r  <= '0;
      cy_r  <= '0;
      cz_r  <= '0;
      rad_r <= (CW - 1)'(1) << FB;
    end else if (cfg_wr.valid) begin
      case (rsi_pkg::cfg_reg_t'(cfg_wr.index))
        rsi_pkg::REG_CENTER_X: cx_r  <= cfg_wr.data;
        rsi_pkg::REG_CENTER_Y: cy_r  <= cfg_wr.data;
        rsi_pkg::REG_CENTER_Z: cz_r  <= cfg_wr.data;
        rsi_pkg::REG_RADIUS:   rad_r <= cfg_wr.data[CW-2:0];
        default: ;
      endcase
    end
  end

  assign cfg_wr.ready = 1'b1;

  // Pipeline advance: move when the output slot is free or being taken
  logic out_valid_r;
  logic en;

  assign en           = !out_valid_r || out_res.ready;
  assign in_ray.ready = en;

  // Stage 1: relative origin L = O - C
  logic                 v1_r;
  logic signed [LW-1:0] lx1_r, ly1_r, lz1_r;
  logic signed [CW-1:0] dx1_r, dy1_r, dz1_r;

  // Stage 2: products
  logic                     v2_r;
  logic signed [2*CW-1:0]   ddx_r, ddy_r, ddz_r;
  logic signed [2*CW:0]     dlx_r, dly_r, dlz_r;
  logic signed [2*LW-1:0]   llx_r, lly_r, llz_r;
  logic [2*CW-3:0]          rr_r;

  // Stage 3: quadratic coefficients
  logic                   v3_r;
  logic [AW-1:0]          a3_r;
  logic signed [BW-1:0]   b3_r;
  logic signed [CCW-1:0]  c3_r;

  // Stage 4a: half-width partial products of b*b and a*c
  logic                     v4p_r;
  logic signed [2*BHW-1:0]  bb_hh_r;
  logic signed [BHW+BLW:0]  bb_hl_r;
  logic [2*BLW-1:0]         bb_ll_r;
  logic signed [AHW+CHW:0]  ac_hh_r;
  logic [AHW+CLW-1:0]       ac_hl_r;
  logic signed [ALW+CHW:0]  ac_lh_r;
  logic [ALW+CLW-1:0]       ac_ll_r;
  logic [AW-1:0]            a4p_r;
  logic signed [BW-1:0]     b4p_r;
  logic signed [CCW-1:0]    c4p_r;

  // Stage 4b: b*b and a*c
  logic                     v4_r;
  logic signed [2*BW-1:0]   bb4_r;
  logic signed [AW+CCW:0]   ac4_r;
  logic                     az4_r;
  logic [AW-1:0]            a4_r;
  logic signed [BW-1:0]     b4_r;
  logic signed [CCW-1:0]    c4_r;

  // Stage 5: discriminant
  logic                   v5_r;
  logic [DXW-1:0]         rad5_r;
  logic [SQSW-1:0]        side5_r;
  logic signed [DXW-1:0]  disc;
  logic                   miss5;

  always_comb begin
    disc  = DXW'(bb4_r) - (DXW'(ac4_r) <<< 2);
    miss5 = az4_r || disc[DXW-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
      v4p_r <= 1'b0;
      v4_r  <= 1'b0;
      v5_r  <= 1'b0;
    end else if (en) begin
      v1_r  <= in_ray.valid;
      v2_r  <= v1_r;
      v3_r  <= v2_r;
      v4p_r <= v3_r;
      v4_r  <= v4p_r;
      v5_r  <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lx1_r <= LW'(in_ray.origin_x) - LW'(cx_r);
      ly1_r <= LW'(in_ray.origin_y) - LW'(cy_r);
      lz1_r <= LW'(in_ray.origin_z) - LW'(cz_r);
      dx1_r <= in_ray.dir_x;
      dy1_r <= in_ray.dir_y;
      dz1_r <= in_ray.dir_z;

      ddx_r <= dx1_r * dx1_r;
      ddy_r <= dy1_r * dy1_r;
      ddz_r <= dz1_r * dz1_r;
      dlx_r <= dx1_r * lx1_r;
      dly_r <= dy1_r * ly1_r;
      dlz_r <= dz1_r * lz1_r;
      llx_r <= lx1_r * lx1_r;
      lly_r <= ly1_r * ly1_r;
      llz_r <= lz1_r * lz1_r;
      rr_r  <= rad_r * rad_r;

      a3_r <= AW'(ddx_r) + AW'(ddy_r) + AW'(ddz_r);
      b3_r <= {PW'(dlx_r) + PW'(dly_r) + PW'(dlz_r), 1'b0};
      c3_r <= CCW'(llx_r) + CCW'(lly_r) + CCW'(llz_r)
              - CCW'($signed({1'b0, rr_r}));

      // Split b, a and c into high and low halves
      bb_hh_r <= $signed(b3_r[BW-1:BLW]) * $signed(b3_r[BW-1:BLW]);
      bb_hl_r <= $signed(b3_r[BW-1:BLW]) * $signed({1'b0, b3_r[BLW-1:0]});
      bb_ll_r <= b3_r[BLW-1:0] * b3_r[BLW-1:0];
      ac_hh_r <= $signed({1'b0, a3_r[AW-1:ALW]}) * $signed(c3_r[CCW-1:CLW]);
      ac_hl_r <= a3_r[AW-1:ALW] * c3_r[CLW-1:0];
      ac_lh_r <= $signed({1'b0, a3_r[ALW-1:0]}) * $signed(c3_r[CCW-1:CLW]);
      ac_ll_r <= a3_r[ALW-1:0] * c3_r[CLW-1:0];
      a4p_r   <= a3_r;
      b4p_r   <= b3_r;
      c4p_r   <= c3_r;

      // Recombine the partial products
      bb4_r <= ((2 * BW)'(bb_hh_r) <<< (2 * BLW))
               + ((2 * BW)'(bb_hl_r) <<< (BLW + 1))
               + (2 * BW)'($signed({1'b0, bb_ll_r}));
      ac4_r <= ((AW + CCW + 1)'(ac_hh_r) <<< (ALW + CLW))
               + ((AW + CCW + 1)'($signed({1'b0, ac_hl_r})) <<< ALW)
               + ((AW + CCW + 1)'(ac_lh_r) <<< CLW)
               + (AW + CCW + 1)'($signed({1'b0, ac_ll_r}));
      az4_r <= (a4p_r == '0);
      a4_r  <= a4p_r;
      b4_r  <= b4p_r;
      c4_r  <= c4p_r;

      rad5_r  <= miss5 ? '0 : disc;
      side5_r <= {a4_r, c4_r, b4_r, miss5};
    end
  end

  // Square root cell chain
  logic [SW:0]      sq_v;
  logic [DXW-1:0]   sq_rad  [SW+1];
  logic [SW+1:0]    sq_rem  [SW+1];
  logic [SW-1:0]    sq_root [SW+1];
  logic [SQSW-1:0]  sq_side [SW+1];

  assign sq_v[0]    = v5_r;
  assign sq_rad[0]  = rad5_r;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_side[0] = side5_r;

  for (genvar g = 0; g < SW; g++) begin : g_sqrt
    rsi_sqrt_cell #(
      .SW    (SW),
      .SIDEW (SQSW)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .v_i    (sq_v[g]),
      .rad_i  (sq_rad[g]),
      .rem_i  (sq_rem[g]),
      .root_i (sq_root[g]),
      .side_i (sq_side[g]),
      .v_o    (sq_v[g+1]),
      .rad_o  (sq_rad[g+1]),
      .rem_o  (sq_rem[g+1]),
      .root_o (sq_root[g+1]),
      .side_o (sq_side[g+1])
    );
  end

  // Stage 6: stable root 2q and divider operands
  logic [AW-1:0]          a6;
  logic signed [CCW-1:0]  c6;
  logic signed [BW-1:0]   b6;
  logic                   miss6;
  logic signed [QW-1:0]   s6;
  logic signed [QW-1:0]   q2;
  logic [DVW-1:0]         qmag;
  logic [CCW-1:0]         cmag;
  logic                   v6_r;
  logic [NW-1:0]          num0_6_r, num1_6_r;
  logic [DVW-1:0]         den0_6_r, den1_6_r;
  logic [DSW-1:0]         side6_r;

  always_comb begin
    {a6, c6, b6, miss6} = sq_side[SW];
    s6   = QW'($signed({1'b0, sq_root[SW]}));
    q2   = (!b6[BW-1] && (b6 != '0)) ? -(QW'(b6) + s6) : s6 - QW'(b6);
    qmag = q2[QW-1] ? DVW'(-q2) : DVW'(q2);
    cmag = c6[CCW-1] ? CCW'(-c6) : CCW'(c6);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else if (en) begin
      v6_r <= sq_v[SW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num0_6_r <= {qmag, {FB{1'b0}}};
      den0_6_r <= DVW'({a6, 1'b0});
      num1_6_r <= {DVW'({cmag, 1'b0}), {FB{1'b0}}};
      den1_6_r <= qmag;
      // miss, zero 2q, sign of t0, sign of t1
      side6_r  <= {miss6, (q2 == '0), q2[QW-1], c6[CCW-1] ^ q2[QW-1]};
    end
  end

  // Divider cell chain for t0 = 2q/2a and t1 = 2c/2q
  logic [NW:0]      dv_v;
  logic [NW-1:0]    dv_num0 [NW+1];
  logic [DVW-1:0]   dv_den0 [NW+1];
  logic [DVW-1:0]   dv_rem0 [NW+1];
  logic [NW-1:0]    dv_quo0 [NW+1];
  logic [NW-1:0]    dv_num1 [NW+1];
  logic [DVW-1:0]   dv_den1 [NW+1];
  logic [DVW-1:0]   dv_rem1 [NW+1];
  logic [NW-1:0]    dv_quo1 [NW+1];
  logic [DSW-1:0]   dv_side [NW+1];

  assign dv_v[0]    = v6_r;
  assign dv_num0[0] = num0_6_r;
  assign dv_den0[0] = den0_6_r;
  assign dv_rem0[0] = '0;
  assign dv_quo0[0] = '0;
  assign dv_num1[0] = num1_6_r;
  assign dv_den1[0] = den1_6_r;
  assign dv_rem1[0] = '0;
  assign dv_quo1[0] = '0;
  assign dv_side[0] = side6_r;

  for (genvar g = 0; g < NW; g++) begin : g_div
    rsi_div_cell #(
      .NW    (NW),
      .DVW   (DVW),
      .SIDEW (DSW)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .v_i    (dv_v[g]),
      .num0_i (dv_num0[g]),
      .den0_i (dv_den0[g]),
      .rem0_i (dv_rem0[g]),
      .quo0_i (dv_quo0[g]),
      .num1_i (dv_num1[g]),
      .den1_i (dv_den1[g]),
      .rem1_i (dv_rem1[g]),
      .quo1_i (dv_quo1[g]),
      .side_i (dv_side[g]),
      .v_o    (dv_v[g+1]),
      .num0_o (dv_num0[g+1]),
      .den0_o (dv_den0[g+1]),
      .rem0_o (dv_rem0[g+1]),
      .quo0_o (dv_quo0[g+1]),
      .num1_o (dv_num1[g+1]),
      .den1_o (dv_den1[g+1]),
      .rem1_o (dv_rem1[g+1]),
      .quo1_o (dv_quo1[g+1]),
      .side_o (dv_side[g+1])
    );
  end

  // Final stage: floor signed roots, order, pick, saturate
  localparam logic [NW:0]   SatHi = {{(NW - CW + 2){1'b0}}, {(CW - 1){1'b1}}};
  localparam logic [CW-1:0] MissDist = {{(CW - FB){1'b1}}, {FB{1'b0}}};

  logic signed [NW:0]   tt0, tt1, t_lo, t_hi, t_sel;
  logic                 fin_miss, fin_qz, fin_s0, fin_s1;
  logic                 hit_nxt;
  logic [CW-1:0]        dist_nxt;
  logic                 hit_r;
  logic [CW-1:0]        dist_r;

  always_comb begin
    {fin_miss, fin_qz, fin_s0, fin_s1} = dv_side[NW];
    tt0 = fin_s0 ? -$signed({1'b0, dv_quo0[NW]}) - (NW + 1)'(dv_rem0[NW] != '0)
                 : $signed({1'b0, dv_quo0[NW]});
    tt1 = fin_s1 ? -$signed({1'b0, dv_quo1[NW]}) - (NW + 1)'(dv_rem1[NW] != '0)
                 : $signed({1'b0, dv_quo1[NW]});
    t_lo  = (tt1 < tt0) ? tt1 : tt0;
    t_hi  = (tt1 < tt0) ? tt0 : tt1;
    t_sel = t_lo[NW] ? t_hi : t_lo;
    hit_nxt  = 1'b0;
    dist_nxt = MissDist;
    if (fin_miss) begin
      hit_nxt  = 1'b0;
    end else if (fin_qz) begin
      hit_nxt  = 1'b1;
      dist_nxt = '0;
    end else if (!t_hi[NW]) begin
      hit_nxt  = 1'b1;
      dist_nxt = (t_sel > $signed(SatHi)) ? CW'(SatHi) : CW'(t_sel);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_v[NW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit_r  <= hit_nxt;
      dist_r <= dist_nxt;
    end
  end

  assign out_res.valid    = out_valid_r;
  assign out_res.hit      = hit_r;
  assign out_res.distance = dist_r;

endmodule

// ===== rtl/core/rsi_checker.sv =====
// Port-level checks for the intersection block, bound to the top level.
`timescale 1ns / 1ps

module rsi_checker #(
  parameter int CW = rsi_pkg::COORD_WIDTH_DEF,
  parameter int FB = rsi_pkg::FRAC_BITS_DEF
) (
  input logic          clk,
  input logic          rst_n,
  input logic          out_valid,
  input logic          out_ready,
  input logic          out_hit,
  input logic [CW-1:0] out_distance
);

  localparam logic [CW-1:0] MissDist = {{(CW - FB){1'b1}}, {FB{1'b0}}};

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_hit) && $stable(out_distance))
    else $error("result changed while stalled");

  // A miss always reports -1.0
  a_miss_dist: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_distance == MissDist)
    else $error("miss without -1.0 distance");

  // A hit is never behind the origin
  a_hit_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> !out_distance[CW-1])
    else $error("hit with negative distance");

  // Drop all results on reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind ray_sphere_intersect rsi_checker #(
  .CW (COORD_WIDTH),
  .FB (FRAC_BITS)
) u_rsi_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_res.valid),
  .out_ready    (out_res.ready),
  .out_hit      (out_res.hit),
  .out_distance (out_res.distance)
);

// ===== verif/tb_ray_sphere_intersect.sv =====
// Self-checking testbench for the ray/sphere intersection pipeline.
`timescale 1ns / 1ps

module tb_ray_sphere_intersect;

  localparam int CW         = rsi_pkg::COORD_WIDTH_DEF;
  localparam int FB         = rsi_pkg::FRAC_BITS_DEF;
  localparam int DRAIN_WAIT = 2 * CW + 5 + 2 * CW + 6 + FB + 8 + 10;
  localparam int N_PHASES   = 7;
  localparam int PER_PHASE  = 230;

  typedef logic signed [255:0] wide_t;
  typedef logic signed [CW-1:0] coord_t;

  typedef struct {
    coord_t ox, oy, oz, dx, dy, dz;
  } ray_t;

  typedef struct {
    logic   hit;
    coord_t dist_val;
  } hit_t;

  typedef struct {
    ray_t ray;
    bit   typed;
    hit_t res;
  } row_t;

  logic clk;
  logic rst_n;

  rsi_ray_if #(.CW(CW)) ray_ch ();
  rsi_res_if #(.CW(CW)) res_ch ();
  rsi_cfg_if #(.CW(CW)) cfg_ch ();

  ray_sphere_intersect #(.COORD_WIDTH(CW), .FRAC_BITS(FB)) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ray  (ray_ch.sink),
    .out_res (res_ch.source),
    .cfg_wr  (cfg_ch.sink)
  );

  // Sphere as the block should hold it
  coord_t      sph_cx, sph_cy, sph_cz;
  logic [30:0] sph_r;

  hit_t        pending_hits[$];
  int unsigned n_err;
  bit          tx_quiet, rx_quiet;
  int unsigned rx_stall;

  localparam coord_t ONE  = 32'sh0001_0000;
  localparam coord_t M1   = 32'shFFFF_0000;
  localparam coord_t M5   = 32'shFFFB_0000;
  localparam coord_t MAXC = 32'sh7FFF_FFFF;
  localparam coord_t MINC = 32'sh8000_0000;

  // Directed rays; expectation typed in where it is obvious
  row_t dir_rows [13] = '{
    '{'{0, 0, M5, 0, 0, ONE},                1, '{1'b1, 32'sh0004_0000}},
    '{'{0, 0, M5, 0, 0, 0},                  1, '{1'b0, M1}},
    '{'{0, 0, M5, 0, 0, M1},                 1, '{1'b0, M1}},
    '{'{0, 32'sh0005_0000, M5, 0, 0, ONE},   1, '{1'b0, M1}},
    '{'{0, 0, 0, ONE, 0, 0},                 1, '{1'b1, ONE}},
    '{'{ONE, 0, 0, 0, ONE, 0},               1, '{1'b1, 0}},
    '{'{0, 0, 32'shFFFE_0000, 0, 0, 1},      0, '{1'b0, 0}},
    '{'{MAXC, MAXC, MAXC, MINC, MINC, MINC}, 0, '{1'b0, 0}},
    '{'{MINC, MINC, MINC, MAXC, MAXC, MAXC}, 0, '{1'b0, 0}},
    '{'{MAXC, MINC, 0, 1, -1, 0},            0, '{1'b0, 0}},
    '{'{0, 0, M5, 0, 0, MAXC},               0, '{1'b0, 0}},
    '{'{0, 0, 0, MINC, 0, 0},                0, '{1'b0, 0}},
    '{'{-1, -1, -1, -1, -1, -1},             0, '{1'b0, 0}}
  };

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic wide_t floor_div(wide_t n, wide_t d);
    wide_t qt, rm;
    qt = n / d;
    rm = n % d;
    if (rm != 0 && ((n < 0) != (d < 0))) qt = qt - 1;
    return qt;
  endfunction

  function automatic wide_t int_sqrt(wide_t v);
    logic [255:0] rt, cand, uv;
    rt = '0;
    uv = v;
    for (int k = 127; k >= 0; k--) begin
      cand = rt | (256'd1 << k);
      if (cand * cand <= uv) rt = cand;
    end
    return rt;
  endfunction

  // Nearest non-negative hit of a ray against the current sphere
  function automatic hit_t trace_ray(ray_t r);
    wide_t lx, ly, lz, dx, dy, dz, rr, a, b, c, disc, s, q2, t0, t1, t;
    hit_t  o;
    o.hit      = 1'b0;
    o.dist_val = M1;
    lx = $signed(r.ox) - $signed(sph_cx);
    ly = $signed(r.oy) - $signed(sph_cy);
    lz = $signed(r.oz) - $signed(sph_cz);
    dx = r.dx;
    dy = r.dy;
    dz = r.dz;
    rr = $signed({225'b0, sph_r});
    a = dx * dx + dy * dy + dz * dz;
    if (a == 0) return o;
    b = (dx * lx + dy * ly + dz * lz) <<< 1;
    c = lx * lx + ly * ly + lz * lz - rr * rr;
    disc = b * b - ((a * c) <<< 2);
    if (disc < 0) return o;
    s  = int_sqrt(disc);
    q2 = (b > 0) ? -(b + s) : s - b;
    if (q2 == 0) begin
      o.hit      = 1'b1;
      o.dist_val = 0;
      return o;
    end
    t0 = floor_div(q2 <<< FB, a <<< 1);
    t1 = floor_div((c <<< 1) <<< FB, q2);
    if (t1 < t0) begin
      t  = t0;
      t0 = t1;
      t1 = t;
    end
    if (t1 < 0) return o;
    t = (t0 < 0) ? t1 : t0;
    if (t > $signed(MAXC)) t = $signed(MAXC);
    o.hit      = 1'b1;
    o.dist_val = t[CW-1:0];
    return o;
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t mismatch: %s", $time, msg);
    n_err++;
  endtask

  // Offer one ray and log its expected hit once it transfers
  task automatic send_ray(ray_t r, bit typed, hit_t typed_res);
    int unsigned g;
    hit_t        e;
    g = tx_quiet ? 0 : pick_gap();
    if (g > 0) begin
      ray_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    ray_ch.valid    <= 1'b1;
    ray_ch.origin_x <= r.ox;
    ray_ch.origin_y <= r.oy;
    ray_ch.origin_z <= r.oz;
    ray_ch.dir_x    <= r.dx;
    ray_ch.dir_y    <= r.dy;
    ray_ch.dir_z    <= r.dz;
    do @(posedge clk); while (!ray_ch.ready);
    e = typed ? typed_res : trace_ray(r);
    pending_hits.push_back(e);
  endtask

  task automatic write_reg(rsi_pkg::cfg_reg_t idx, logic [CW-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      rsi_pkg::REG_CENTER_X: sph_cx = val;
      rsi_pkg::REG_CENTER_Y: sph_cy = val;
      rsi_pkg::REG_CENTER_Z: sph_cz = val;
      rsi_pkg::REG_RADIUS:   sph_r  = val[30:0];
      default: ;
    endcase
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Hold until every result is back and the pipeline is empty
  task automatic drain();
    ray_ch.valid <= 1'b0;
    while (pending_hits.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  function automatic coord_t near_value(coord_t base, longint span);
    longint off;
    off = longint'($urandom_range(0, 32'(2 * span))) - span;
    return coord_t'(longint'(base) + off);
  endfunction

  // Random ray: mostly aimed near the sphere, some raw noise
  function automatic ray_t make_ray();
    ray_t        r;
    int unsigned kind, sh;
    longint      span;
    kind = $urandom_range(0, 9);
    span = longint'(sph_r) * 3 + 64;
    if (span > 64'd1073741823) span = 64'd1073741823;
    r.ox = near_value(sph_cx, span);
    r.oy = near_value(sph_cy, span);
    r.oz = near_value(sph_cz, span);
    sh   = $urandom_range(4, 20);
    r.dx = near_value(0, 64'd1 << sh);
    r.dy = near_value(0, 64'd1 << sh);
    r.dz = near_value(0, 64'd1 << sh);
    if (kind < 2) begin
      r = '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    end else if (kind == 2) begin
      r.dx = 0;
      r.dy = 0;
      r.dz = ($urandom_range(0, 1) == 0) ? 0 : r.dz;
    end else if (kind < 7) begin
      // aim toward the center with some jitter
      r.dx = ((sph_cx - r.ox) >>> $urandom_range(0, 4)) + coord_t'($urandom_range(0, 15));
      r.dy = ((sph_cy - r.oy) >>> $urandom_range(0, 4)) + coord_t'($urandom_range(0, 15));
      r.dz = ((sph_cz - r.oz) >>> $urandom_range(0, 4)) + coord_t'($urandom_range(0, 15));
    end
    return r;
  endfunction

  // Result side: random back-pressure and check against the oldest expectation
  always @(posedge clk) begin
    hit_t e;
    if (!rst_n) begin
      rx_stall     <= 0;
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (pending_hits.size() == 0) begin
          report_mismatch("result with nothing pending");
        end else begin
          e = pending_hits.pop_front();
          if (res_ch.hit !== e.hit)
            report_mismatch($sformatf("hit %b, want %b", res_ch.hit, e.hit));
          if (res_ch.distance !== e.dist_val)
            report_mismatch($sformatf("distance %h, want %h", res_ch.distance,
                                      e.dist_val));
        end
      end
      if (rx_stall > 0) begin
        rx_stall     <= rx_stall - 1;
        res_ch.ready <= 1'b0;
      end else if (!rx_quiet && $urandom_range(0, 3) == 0) begin
        rx_stall     <= pick_gap();
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    hit_t              none;
    rsi_pkg::cfg_reg_t idx;
    none            = '{1'b0, 0};
    tx_quiet        = 1'b0;
    rx_quiet        = 1'b0;
    sph_cx          = 0;
    sph_cy          = 0;
    sph_cz          = 0;
    sph_r           = 31'(ONE);
    rst_n           = 1'b0;
    ray_ch.valid    = 1'b0;
    ray_ch.origin_x = '0;
    ray_ch.origin_y = '0;
    ray_ch.origin_z = '0;
    ray_ch.dir_x    = '0;
    ray_ch.dir_y    = '0;
    ray_ch.dir_z    = '0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = rsi_pkg::REG_CENTER_X;
    cfg_ch.data     = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rays against the reset sphere
    foreach (dir_rows[i]) send_ray(dir_rows[i].ray, dir_rows[i].typed, dir_rows[i].res);

    for (int ph = 0; ph < N_PHASES; ph++) begin
      drain();
      case (ph)
        0: begin
          write_reg(rsi_pkg::REG_CENTER_X, MAXC);
          write_reg(rsi_pkg::REG_CENTER_Y, MINC);
          write_reg(rsi_pkg::REG_CENTER_Z, 0);
          write_reg(rsi_pkg::REG_RADIUS, 32'hFFFF_FFFF);
        end
        1: begin
          write_reg(rsi_pkg::REG_CENTER_X, $urandom_range(0, 32'h00FF_FFFF));
          write_reg(rsi_pkg::REG_CENTER_Y, -$urandom_range(0, 32'h00FF_FFFF));
          write_reg(rsi_pkg::REG_CENTER_Z, $urandom_range(0, 32'h0000_FFFF));
          write_reg(rsi_pkg::REG_RADIUS, 32'h8000_0000);
        end
        2: begin
          write_reg(rsi_pkg::REG_CENTER_X, MINC);
          write_reg(rsi_pkg::REG_CENTER_Y, MINC);
          write_reg(rsi_pkg::REG_CENTER_Z, MINC);
          write_reg(rsi_pkg::REG_RADIUS, $urandom);
        end
        default: begin
          for (int k = 0; k < 4; k++) begin
            idx = rsi_pkg::cfg_reg_t'($urandom_range(0, 3));
            if (idx == rsi_pkg::REG_RADIUS)
              write_reg(idx, {$urandom_range(0, 1) == 1, 31'($urandom_range(0, 32'h0100_0000))});
            else
              write_reg(idx, $signed($urandom_range(0, 32'h2000_0000)) - 32'sh1000_0000);
          end
        end
      endcase
      tx_quiet = ($urandom_range(0, 2) == 0);
      rx_quiet = ($urandom_range(0, 2) == 0);
      for (int n = 0; n < PER_PHASE; n++) send_ray(make_ray(), 1'b0, none);
      ray_ch.valid <= 1'b0;
    end

    drain();
    if (n_err == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
